// ===== rtl/core/taar_pkg.sv =====
// Shared constants for the triangle area and aspect ratio pipeline.
package taar_pkg;

   // Default coordinate width of one vertex component.
   localparam int COORD_WIDTH_DEF = 16;

   // Result field widths and positions inside rsp_tdata.
   localparam int AREA_W    = 34;
   localparam int RATIO_W   = 25;
   localparam int FRAC_W    = 8;
   localparam int RATIO_LSB = AREA_W;
   localparam int DEGEN_BIT = AREA_W + RATIO_W;
   localparam int RSP_W     = ((AREA_W + RATIO_W + 1 + 7) / 8) * 8;

   // Squared edge lengths are scaled by this many bits before the root.
   localparam int LEN_SHIFT = 16;

endpackage

// ===== rtl/core/triangle_area_aspect_ratio_top.sv =====
// Top level: triangle double area and edge aspect ratio pipeline.
// Throughput is one triangle per cycle while the result side does not stall; the whole pipeline moves on one enable.
// The path length is set by the edge-length root stages plus the restoring divider.
// Synchronous active-high reset clears all valid bits; data registers are not reset.
module triangle_area_aspect_ratio_top #(
   parameter int COORD_WIDTH = taar_pkg::COORD_WIDTH_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, each COORD_WIDTH bits, lowest first
   input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]       req_tdata,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // double_area [33:0], aspect_ratio [58:34], degenerate [59], zero padded
   output logic [taar_pkg::RSP_W-1:0]               rsp_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready
);

   localparam int CW   = COORD_WIDTH;
   localparam int D    = CW + 1;
   localparam int PW   = 2 * D;
   localparam int XW   = 2 * D + 1;
   localparam int SW4  = 4 * D;
   localparam int SQW  = 4 * D + 2;
   localparam int ARW  = (SQW + 1) / 2;
   localparam int ESW  = PW + 2 + taar_pkg::LEN_SHIFT;
   localparam int LW   = (ESW + 1) / 2;
   localparam int QW   = LW + taar_pkg::FRAC_W;
   localparam int NST  = 5 + LW + QW;
   localparam int ADLY = NST - 7 - ARW;
   localparam int AXW  = (ARW > taar_pkg::AREA_W) ? ARW : taar_pkg::AREA_W;

   // Global pipeline enable and valid bits.
   logic           en;
   logic [NST-1:0] vld_ff;

   assign en         = !vld_ff[NST-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], req_tvalid};
      end
   end

   // Stage 1: coordinate differences.
   logic signed [CW-1:0] crd [9];
   logic signed [D-1:0]  u_ff [3];
   logic signed [D-1:0]  v_ff [3];
   logic signed [D-1:0]  w_ff [3];

   genvar k;
   generate
      for (k = 0; k < 9; k++) begin : g_crd
         assign crd[k] = signed'(req_tdata[k*CW +: CW]);
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            u_ff[i] <= {crd[3+i][CW-1], crd[3+i]} - {crd[i][CW-1], crd[i]};
            v_ff[i] <= {crd[6+i][CW-1], crd[6+i]} - {crd[i][CW-1], crd[i]};
            w_ff[i] <= {crd[6+i][CW-1], crd[6+i]} - {crd[3+i][CW-1], crd[3+i]};
         end
      end
   end

   // Stage 2: cross product terms and squared edge components.
   logic signed [PW-1:0] cp_ff [6];
   logic signed [PW-1:0] eq_ff [9];

   always_ff @(posedge clock) begin
      if (en) begin
         cp_ff[0] <= u_ff[1] * v_ff[2];
         cp_ff[1] <= u_ff[2] * v_ff[1];
         cp_ff[2] <= u_ff[2] * v_ff[0];
         cp_ff[3] <= u_ff[0] * v_ff[2];
         cp_ff[4] <= u_ff[0] * v_ff[1];
         cp_ff[5] <= u_ff[1] * v_ff[0];
         for (int i = 0; i < 3; i++) begin
            eq_ff[i]     <= u_ff[i] * u_ff[i];
            eq_ff[3 + i] <= w_ff[i] * w_ff[i];
            eq_ff[6 + i] <= v_ff[i] * v_ff[i];
         end
      end
   end

   // Stage 3: cross product magnitudes and squared edge lengths.
   logic signed [XW-1:0] x_cmb [3];
   logic [PW-1:0]        xm_ff [3];
   logic [PW+1:0]        es_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         x_cmb[i] = {cp_ff[2*i][PW-1], cp_ff[2*i]} - {cp_ff[2*i+1][PW-1], cp_ff[2*i+1]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            xm_ff[i] <= x_cmb[i][XW-1] ? PW'(-x_cmb[i]) : PW'(x_cmb[i]);
            es_ff[i] <= (PW+2)'(unsigned'(eq_ff[3*i])) + (PW+2)'(unsigned'(eq_ff[3*i+1]))
                      + (PW+2)'(unsigned'(eq_ff[3*i+2]));
         end
      end
   end

   // Stage 4: split squares of the cross magnitudes into partial products.
   logic [PW-1:0] hh_ff [3];
   logic [PW-1:0] hl_ff [3];
   logic [PW-1:0] ll_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            hh_ff[i] <= xm_ff[i][PW-1:D] * xm_ff[i][PW-1:D];
            hl_ff[i] <= xm_ff[i][PW-1:D] * xm_ff[i][D-1:0];
            ll_ff[i] <= xm_ff[i][D-1:0] * xm_ff[i][D-1:0];
         end
      end
   end

   // Stage 5: recombine each square.
   logic [SW4-1:0] sq_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= (SW4'(hh_ff[i]) << PW) + (SW4'(hl_ff[i]) << (D + 1))
                      + SW4'(ll_ff[i]);
         end
      end
   end

   // Stage 6: squared cross product length.
   logic [SQW-1:0] sum_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= SQW'(sq_ff[0]) + SQW'(sq_ff[1]) + SQW'(sq_ff[2]);
      end
   end

   // Root of the squared cross length.
   logic [ARW-1:0] area_root;

   taar_sqrt #(.NW(SQW)) u_area_sqrt (
      .clock    (clock),
      .en       (en),
      .n_in     (sum_ff),
      .root_out (area_root)
   );

   // Delay the area to line up with the ratio path.
   logic [ARW-1:0] ad_ff [ADLY];

   always_ff @(posedge clock) begin
      if (en) begin
         ad_ff[0] <= area_root;
         for (int i = 1; i < ADLY; i++) begin
            ad_ff[i] <= ad_ff[i-1];
         end
      end
   end

   // Edge length roots, scaled for eight fractional bits.
   logic [LW-1:0] len [3];

   generate
      for (k = 0; k < 3; k++) begin : g_edge
         taar_sqrt #(.NW(ESW)) u_edge_sqrt (
            .clock    (clock),
            .en       (en),
            .n_in     ({es_ff[k], {taar_pkg::LEN_SHIFT{1'b0}}}),
            .root_out (len[k])
         );
      end
   endgenerate

   // Longest and shortest edge.
   logic [LW-1:0] lmax_cmb;
   logic [LW-1:0] lmin_cmb;
   logic [LW-1:0] lmax_ff;
   logic [LW-1:0] lmin_ff;

   always_comb begin
      lmax_cmb = len[0];
      lmin_cmb = len[0];
      if (len[1] > lmax_cmb) lmax_cmb = len[1];
      if (len[2] > lmax_cmb) lmax_cmb = len[2];
      if (len[1] < lmin_cmb) lmin_cmb = len[1];
      if (len[2] < lmin_cmb) lmin_cmb = len[2];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lmax_ff <= lmax_cmb;
         lmin_ff <= lmin_cmb;
      end
   end

   // Restoring divider, one quotient bit per stage.
   logic [LW-1:0] r_ff  [QW];
   logic [QW-1:0] nq_ff [QW];
   logic [LW-1:0] dv_ff [QW];
   logic          dg_ff [QW];

   generate
      for (k = 0; k < QW; k++) begin : g_div
         logic [LW-1:0] r_prev;
         logic [QW-1:0] nq_prev;
         logic [LW-1:0] d_prev;
         logic          dg_prev;
         logic [LW:0]   t;
         logic          ge;
         logic [LW:0]   diff;

         if (k == 0) begin : g_first
            assign r_prev  = '0;
            assign nq_prev = {lmax_ff, {taar_pkg::FRAC_W{1'b0}}};
            assign d_prev  = lmin_ff;
            assign dg_prev = (lmin_ff == '0);
         end else begin : g_next
            assign r_prev  = r_ff[k-1];
            assign nq_prev = nq_ff[k-1];
            assign d_prev  = dv_ff[k-1];
            assign dg_prev = dg_ff[k-1];
         end

         assign t    = {r_prev, nq_prev[QW-1]};
         assign diff = t - {1'b0, d_prev};
         assign ge   = (t >= {1'b0, d_prev});

         always_ff @(posedge clock) begin
            if (en) begin
               r_ff[k]  <= ge ? diff[LW-1:0] : t[LW-1:0];
               nq_ff[k] <= {nq_prev[QW-2:0], ge};
               dv_ff[k] <= d_prev;
               dg_ff[k] <= dg_prev;
            end
         end
      end
   endgenerate

   // Output register with saturation and the degenerate override.
   logic [AXW-1:0]                  area_ext;
   logic [taar_pkg::AREA_W-1:0]     area_cmb;
   logic [taar_pkg::RATIO_W-1:0]    ratio_cmb;
   logic [taar_pkg::AREA_W-1:0]     area_ff;
   logic [taar_pkg::RATIO_W-1:0]    ratio_ff;
   logic                            degen_ff;

   always_comb begin
      area_ext = AXW'(ad_ff[ADLY-1]);
      if (area_ext > AXW'({taar_pkg::AREA_W{1'b1}})) begin
         area_cmb = '1;
      end else begin
         area_cmb = area_ext[taar_pkg::AREA_W-1:0];
      end
      if (dg_ff[QW-1]) begin
         ratio_cmb = '0;
      end else if (nq_ff[QW-1] > QW'({taar_pkg::RATIO_W{1'b1}})) begin
         ratio_cmb = '1;
      end else begin
         ratio_cmb = nq_ff[QW-1][taar_pkg::RATIO_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         area_ff  <= area_cmb;
         ratio_ff <= ratio_cmb;
         degen_ff <= dg_ff[QW-1];
      end
   end

   assign rsp_tdata = taar_pkg::RSP_W'({degen_ff, ratio_ff, area_ff});

endmodule

// ===== rtl/core/taar_sqrt.sv =====
// Pipelined floor square root, one result bit per register stage.
module taar_sqrt #(
   parameter int NW = 70
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [NW-1:0]          n_in,
   output logic [(NW+1)/2-1:0]    root_out
);

   localparam int RW = (NW + 1) / 2;
   localparam int TW = 2 * RW;

   logic [RW-1:0] root_ff [RW];
   logic [TW-1:0] rem_ff  [RW];

   genvar g;
   generate
      for (g = 0; g < RW; g++) begin : g_stage
         localparam int B = RW - 1 - g;
         logic [TW-1:0] rem_prev;
         logic [RW-1:0] root_prev;
         logic [TW-1:0] trial;
         logic          take;
         logic [TW-1:0] rem_in;
         logic [RW-1:0] root_in;

         // Previous remainder and partial root.
         if (g == 0) begin : g_first
            assign rem_prev  = TW'(n_in);
            assign root_prev = '0;
         end else begin : g_next
            assign rem_prev  = rem_ff[g-1];
            assign root_prev = root_ff[g-1];
         end

         // Setting bit B raises the square by (root << (B+1)) + 4^B.
         assign trial   = (TW'(root_prev) << (B + 1)) | (TW'(1) << (2 * B));
         assign take    = (rem_prev >= trial);
         assign rem_in  = take ? (rem_prev - trial) : rem_prev;
         assign root_in = take ? (root_prev | (RW'(1) << B)) : root_prev;

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[g]  <= rem_in;
               root_ff[g] <= root_in;
            end
         end
      end
   endgenerate

   assign root_out = root_ff[RW-1];

endmodule

// ===== rtl/core/taar_checker.sv =====
// Port-level assertions for the triangle area and aspect ratio top level.
module taar_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tready,
   input logic [taar_pkg::RSP_W-1:0]  rsp_tdata,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready
);

   logic                          degen;
   logic [taar_pkg::RATIO_W-1:0]  ratio;

   assign degen = rsp_tdata[taar_pkg::DEGEN_BIT];
   assign ratio = rsp_tdata[taar_pkg::RATIO_LSB +: taar_pkg::RATIO_W];

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result transaction offered right after reset");

   // A stalled result transaction holds its data.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result transaction changed");

   // The input side only stalls when the result side does.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && !rsp_tready) |-> req_tready)
      else $error("input stalled without an output stall");

   // A degenerate triangle reports a zero ratio.
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && degen |-> ratio == '0)
      else $error("degenerate triangle with nonzero ratio");

   // Longest over shortest is at least one.
   a_ratio_min: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !degen |-> ratio >= taar_pkg::RATIO_W'(1 << taar_pkg::FRAC_W))
      else $error("aspect ratio below one");

endmodule

bind triangle_area_aspect_ratio_top taar_checker u_taar_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the triangle double-area and aspect-ratio pipeline.
module tb_top;

   localparam int CW     = taar_pkg::COORD_WIDTH_DEF;
   localparam int REQ_W  = ((9*CW+7)/8)*8;
   localparam int LAT    = 2*CW+33;
   localparam longint LIMIT = 64'd2_000_000;

   typedef struct packed {
      logic [taar_pkg::AREA_W-1:0]  double_area;
      logic [taar_pkg::RATIO_W-1:0] aspect_ratio;
      logic                         degenerate;
   } metric_type;

   logic                       clock;
   logic                       reset;
   logic [REQ_W-1:0]           req_tdata;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [taar_pkg::RSP_W-1:0] rsp_tdata;
   logic                       rsp_tvalid;
   logic                       rsp_tready;

   metric_type metric_q[$];
   int         send_idle_pct;
   int         recv_idle_pct;
   int         error_count;
   longint     cycle_count;

   triangle_area_aspect_ratio_top #(.COORD_WIDTH(CW)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Floor square root of an unsigned 128-bit value, one bit at a time.
   function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
      logic [63:0]  r;
      logic [63:0]  cand;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         cand = r | (64'd1 << b);
         if ({64'd0, cand} * {64'd0, cand} <= n) r = cand;
      end
      return r;
   endfunction

   // Edge length with 8 fractional bits.
   function automatic logic [63:0] edge_length(input longint p[3], input longint q[3]);
      logic [127:0] s;
      longint d;
      s = '0;
      for (int i = 0; i < 3; i++) begin
         d = q[i] - p[i];
         s += 128'(d * d);
      end
      return floor_sqrt(s << taar_pkg::LEN_SHIFT);
   endfunction

   // Expected double area, aspect ratio and degenerate flag of one triangle.
   function automatic metric_type triangle_metrics(input logic [REQ_W-1:0] tri_data);
      longint a[3], b[3], c[3], u[3], v[3], x[3];
      logic [127:0] sq;
      logic [63:0]  area, l0, l1, l2, lmax, lmin, ratio;
      metric_type m;
      for (int i = 0; i < 3; i++) begin
         a[i] = longint'($signed(tri_data[i*CW +: CW]));
         b[i] = longint'($signed(tri_data[(3+i)*CW +: CW]));
         c[i] = longint'($signed(tri_data[(6+i)*CW +: CW]));
         u[i] = b[i] - a[i];
         v[i] = c[i] - a[i];
      end
      x[0] = u[1]*v[2] - u[2]*v[1];
      x[1] = u[2]*v[0] - u[0]*v[2];
      x[2] = u[0]*v[1] - u[1]*v[0];
      sq = '0;
      for (int i = 0; i < 3; i++) begin
         sq += 128'($signed(x[i])) * 128'($signed(x[i]));
      end
      area = floor_sqrt(sq);
      if (area > 64'h3_FFFF_FFFF) area = 64'h3_FFFF_FFFF;
      l0 = edge_length(a, b);
      l1 = edge_length(b, c);
      l2 = edge_length(c, a);
      lmax = l0;
      if (l1 > lmax) lmax = l1;
      if (l2 > lmax) lmax = l2;
      lmin = l0;
      if (l1 < lmin) lmin = l1;
      if (l2 < lmin) lmin = l2;
      m.double_area = area[taar_pkg::AREA_W-1:0];
      if (lmin == 0) begin
         m.aspect_ratio = '0;
         m.degenerate   = 1'b1;
      end else begin
         ratio = (lmax << taar_pkg::FRAC_W) / lmin;
         if (ratio > 64'h1FF_FFFF) ratio = 64'h1FF_FFFF;
         m.aspect_ratio = ratio[taar_pkg::RATIO_W-1:0];
         m.degenerate   = 1'b0;
      end
      return m;
   endfunction

   // Append one expected result to the scoreboard.
   function automatic void queue_expected(input metric_type m);
      metric_q = {metric_q, m};
   endfunction

   // Send one triangle and record its expected metrics on acceptance.
   task automatic send_triangle(input logic [REQ_W-1:0] tri_data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= tri_data;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      queue_expected(triangle_metrics(tri_data));
   endtask

   function automatic logic [REQ_W-1:0] pack_triangle(input logic [CW-1:0] c[9]);
      logic [REQ_W-1:0] d;
      d = '0;
      for (int i = 0; i < 9; i++) d[i*CW +: CW] = c[i];
      return d;
   endfunction

   function automatic logic [CW-1:0] rand_coord(input int mode);
      case (mode)
         0:       return CW'($urandom);
         1:       return CW'($signed($urandom_range(64)) - 32);
         2:       return $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
         default: return CW'($urandom_range(4095));
      endcase
   endfunction

   // Directed cases: extreme coordinates, zero-length edges, collinear points.
   task automatic test_directed();
      logic [CW-1:0] maxv, minv;
      logic [CW-1:0] c[9];
      maxv = {1'b0, {(CW-1){1'b1}}};
      minv = {1'b1, {(CW-1){1'b0}}};
      c = '{default: '0};
      send_triangle(pack_triangle(c));
      c = '{default: maxv};
      send_triangle(pack_triangle(c));
      c = '{default: minv};
      send_triangle(pack_triangle(c));
      c = '{minv, minv, minv, maxv, maxv, maxv, minv, maxv, minv};
      send_triangle(pack_triangle(c));
      c = '{minv, minv, minv, maxv, minv, minv, minv, maxv, minv};
      send_triangle(pack_triangle(c));
      c = '{minv, minv, maxv, maxv, minv, minv, minv, maxv, minv};
      send_triangle(pack_triangle(c));
      c = '{maxv, minv, minv, minv, maxv, minv, minv, minv, maxv};
      send_triangle(pack_triangle(c));
      // Two coincident vertices give a zero-length edge.
      c = '{CW'(1), CW'(2), CW'(3), CW'(1), CW'(2), CW'(3), CW'(100), CW'(-5), CW'(7)};
      send_triangle(pack_triangle(c));
      c = '{CW'(10), CW'(0), CW'(0), CW'(0), CW'(0), CW'(0), CW'(10), CW'(0), CW'(0)};
      send_triangle(pack_triangle(c));
      // Collinear but distinct points: zero area, finite ratio.
      c = '{CW'(0), CW'(0), CW'(0), CW'(1), CW'(1), CW'(1), CW'(2), CW'(2), CW'(2)};
      send_triangle(pack_triangle(c));
      // A very thin triangle pushes the ratio high.
      c = '{minv, minv, minv, maxv, maxv, maxv, minv, minv, CW'(-32767)};
      send_triangle(pack_triangle(c));
      c = '{CW'(0), CW'(0), CW'(0), CW'(1), CW'(0), CW'(0), CW'(0), CW'(1), CW'(0)};
      send_triangle(pack_triangle(c));
      c = '{CW'(16'hAAAA), CW'(16'h5555), CW'(16'hAAAA), CW'(16'h5555), CW'(16'hAAAA),
            CW'(16'h5555), CW'(16'hFFFF), CW'(0), CW'(1)};
      send_triangle(pack_triangle(c));
   endtask

   // Random triangles with a mix of wide, small, extreme and mid-range coordinates.
   task automatic test_random(input int count);
      logic [CW-1:0] c[9];
      int mode;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(9);
         for (int i = 0; i < 9; i++) begin
            c[i] = rand_coord(mode < 5 ? 0 : mode < 7 ? 1 : mode < 8 ? 2 : 3);
         end
         // Occasionally collapse one vertex onto another.
         if ($urandom_range(19) == 0) begin
            for (int i = 0; i < 3; i++) c[3+i] = c[i];
         end
         send_triangle(pack_triangle(c));
      end
   endtask

   task automatic wait_drained();
      while (metric_q.size() != 0) @(posedge clock);
      repeat (LAT + 10) @(posedge clock);
   endtask

   // Result checker and receiver stall generator.
   always @(posedge clock) begin
      metric_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.double_area  = rsp_tdata[taar_pkg::AREA_W-1:0];
            got.aspect_ratio = rsp_tdata[taar_pkg::RATIO_LSB +: taar_pkg::RATIO_W];
            got.degenerate   = rsp_tdata[taar_pkg::DEGEN_BIT];
            if (metric_q.size() == 0) begin
               $error("unexpected transaction: %h", rsp_tdata);
               error_count++;
            end else begin
               want = metric_q.pop_front();
               if (got.double_area !== want.double_area) begin
                  $error("double_area expected %0d actual %0d",
                         want.double_area, got.double_area);
                  error_count++;
               end
               if (got.aspect_ratio !== want.aspect_ratio) begin
                  $error("aspect_ratio expected %0d actual %0d",
                         want.aspect_ratio, got.aspect_ratio);
                  error_count++;
               end
               if (got.degenerate !== want.degenerate) begin
                  $error("degenerate expected %0d actual %0d",
                         want.degenerate, got.degenerate);
                  error_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      error_count   = 0;
      cycle_count   = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 30;
      recv_idle_pct = 81;
      test_directed();
      test_random(500);
      send_idle_pct = 81;
      recv_idle_pct = 30;
      test_random(500);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(500);
      req_tvalid <= 1'b0;
      wait_drained();

      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
